/* hdl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and controller/datapath interface types for the
// sliding window median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int DATA_W     = 32;
    localparam int WSIZE_W    = 7;
    localparam int WSIZE_RST  = 3;
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    typedef struct packed {
        logic accept;    // latch sample, issue ring read
        logic remove;    // take oldest sample out of sorted cells
        logic insert;    // insert sample, write ring, advance pointer
        logic load_out;  // capture median into output register
    } swm_cmd_t;

    typedef struct packed {
        logic full;      // window holds eff samples
        logic last;      // next insert fills the window
    } swm_sts_t;

endpackage

`default_nettype wire

/* hdl/swm_datapath.sv */
// ----------------------------------------------------------------------------
// swm_datapath
// Arrival ring memory, row of sorted cells with parallel shift-remove and
// shift-insert, window counters and the median output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_datapath (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire swm_pkg::swm_cmd_t                  cmd,
    output swm_pkg::swm_sts_t                       sts,
    input  wire logic                               cfg_we,
    input  wire logic [swm_pkg::WSIZE_W-1:0]        cfg_wdata,
    input  wire logic signed [swm_pkg::DATA_W-1:0]  sample,
    output logic signed [swm_pkg::DATA_W-1:0]       median
);
    import swm_pkg::*;

    logic signed [DATA_W-1:0] ring_mem [WINDOW_MAX];
    logic signed [DATA_W-1:0] old_reg;
    logic signed [DATA_W-1:0] sample_reg;
    logic signed [DATA_W-1:0] median_reg;
    logic signed [DATA_W-1:0] sorted_reg  [WINDOW_MAX];
    logic signed [DATA_W-1:0] sorted_next [WINDOW_MAX];

    logic [WSIZE_W-1:0] wsize_reg;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   eff;
    logic [CNT_W-1:0]   ins_count;
    logic [CNT_W-1:0]   ptr_inc;
    logic [IDX_W-1:0]   mid;
    logic [WINDOW_MAX-1:0] gt;
    logic [WINDOW_MAX-1:0] ge;

    always_comb begin
        if (wsize_reg == '0) begin
            eff = CNT_W'(1);
        end else if (int'(wsize_reg) > WINDOW_MAX) begin
            eff = CNT_W'(WINDOW_MAX);
        end else begin
            eff = CNT_W'(wsize_reg);
        end
    end

    assign mid       = IDX_W'((eff - CNT_W'(1)) >> 1);
    assign sts.full  = (fill_reg == eff);
    assign sts.last  = ((fill_reg + CNT_W'(1)) == eff);
    assign ins_count = sts.full ? (fill_reg - CNT_W'(1)) : fill_reg;
    assign ptr_inc   = CNT_W'(ptr_reg) + CNT_W'(1);

    // per-cell compares: entries past the live count act as +infinity
    always_comb begin
        for (int j = 0; j < WINDOW_MAX; j++) begin
            gt[j] = (CNT_W'(j) < ins_count) ? (sorted_reg[j] > sample_reg) : 1'b1;
            ge[j] = (CNT_W'(j) < fill_reg) ? (sorted_reg[j] >= old_reg) : 1'b1;
        end
    end

    always_comb begin
        for (int j = 0; j < WINDOW_MAX; j++) begin
            sorted_next[j] = sorted_reg[j];
            if (cmd.remove) begin
                if (ge[j] && (j + 1 < WINDOW_MAX)) begin
                    sorted_next[j] = sorted_reg[(j + 1) % WINDOW_MAX];
                end
            end else if (cmd.insert) begin
                if ((j > 0) && gt[(j + WINDOW_MAX - 1) % WINDOW_MAX]) begin
                    sorted_next[j] = sorted_reg[(j + WINDOW_MAX - 1) % WINDOW_MAX];
                end else if (gt[j]) begin
                    sorted_next[j] = sample_reg;
                end
            end
        end
    end

    always_comb begin
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        if (cfg_we) begin
            fill_next = '0;
            ptr_next  = '0;
        end else if (cmd.insert) begin
            fill_next = sts.full ? fill_reg : (fill_reg + CNT_W'(1));
            ptr_next  = (ptr_inc < eff) ? IDX_W'(ptr_inc) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsize_reg <= WSIZE_W'(WSIZE_RST);
            fill_reg  <= '0;
            ptr_reg   <= '0;
        end else begin
            if (cfg_we) begin
                wsize_reg <= cfg_wdata;
            end
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= sample;
            old_reg    <= ring_mem[ptr_reg];
        end
        if (cmd.insert) begin
            ring_mem[ptr_reg] <= sample_reg;
        end
        if (cmd.load_out) begin
            median_reg <= sorted_reg[mid];
        end
        for (int j = 0; j < WINDOW_MAX; j++) begin
            sorted_reg[j] <= sorted_next[j];
        end
    end

    assign median = median_reg;

    insert_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> (ins_count < eff))
        else $error("insert beyond window");

    remove_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.remove |-> sts.full)
        else $error("remove while window not full");

    ptr_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |=> (CNT_W'(ptr_reg) < eff))
        else $error("ring pointer outside window");

endmodule

`default_nettype wire

/* hdl/swm_ctrl.sv */
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer for one item: accept, optional remove, insert, optional emit.
// Owns the input ready and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output swm_pkg::swm_cmd_t      cmd,
    input  wire swm_pkg::swm_sts_t sts
);
    import swm_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        REMOVE,
        INSERT,
        EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = sts.full ? REMOVE : INSERT;
                end
            end
            REMOVE: begin
                cmd.remove = 1'b1;
                state_next = INSERT;
            end
            INSERT: begin
                cmd.insert = 1'b1;
                state_next = (sts.full || sts.last) ? EMIT : IDLE;
            end
            EMIT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    accept_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == REMOVE || state_reg == INSERT))
        else $error("accepted item not processed");

    emit_waits_for_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == EMIT && m_valid_reg && !m_ready) |=> (state_reg == EMIT))
        else $error("result overwrote pending output");

    remove_then_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == REMOVE) |=> (state_reg == INSERT))
        else $error("remove not followed by insert");

endmodule

`default_nettype wire

/* hdl/sliding_window_median.sv */
// ----------------------------------------------------------------------------
// sliding_window_median
// Lower median of the most recent window_size signed samples.
// ----------------------------------------------------------------------------
// Input channel s_valid/s_ready/s_sample carries one sample per item; output
// channel m_valid/m_ready/m_median carries one median per item once the
// window is full. Items before the window fills give no result.
// cfg_we/cfg_wdata write window_size (0 acts as 1, above 64 acts as 64);
// a write restarts the window from empty. Write only while idle.
// Steps: an item goes through the sequencer as accept, insert while the
// window is filling, as accept, insert, emit for the item that fills it
// and as accept, remove, insert, emit once full (remove takes out the
// oldest sample), set by the single row of sorted cells that does one
// shift-remove or one shift-insert per cycle. The emit step loads the
// median into m_median and raises m_valid, waiting while the output is
// held. A new item is accepted only after the previous one's last step.
// s_ready is high only while the sequencer waits for an item; a new item is
// taken while a previous median still waits on the output. If the receiver
// stalls, the next median waits in the emit step until the output frees.
// Reset (aresetn low, synchronous) empties the window, sets window_size to
// 3 and drops m_valid. Sample storage is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [swm_pkg::DATA_W-1:0]  s_sample,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [swm_pkg::DATA_W-1:0]       m_median,
    input  wire logic                               cfg_we,
    input  wire logic [swm_pkg::WSIZE_W-1:0]        cfg_wdata
);
    import swm_pkg::*;

    swm_cmd_t cmd;
    swm_sts_t sts;

    swm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    swm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample    (s_sample),
        .median    (m_median)
    );

endmodule

`default_nettype wire
